// ===== src/ssw_pkg.sv =====
// shared types and constants for the smbios structure walker
package ssw_pkg;

  // parse phase of the current structure
  typedef enum logic [1:0] {
    PH_HEADER    = 2'd0,
    PH_FORMATTED = 2'd1,
    PH_STRINGS   = 2'd2
  } phase_t;

  // walker state carried from one table byte to the next
  typedef struct packed {
    logic [15:0] byte_pos;
    logic [15:0] start_pos;
    phase_t      phase;
    logic [7:0]  fmt_len;
    logic [7:0]  held_type;
    logic [15:0] held_handle;
    logic        prev_zero;
    logic [15:0] seen;
    logic        stopped;
  } walk_state_t;

  // one structure record
  typedef struct packed {
    logic [15:0] index;
    logic [7:0]  stype;
    logic [15:0] handle;
    logic [15:0] length;
    logic [15:0] offset;
    logic        truncated;
  } walk_result_t;

  localparam logic [7:0]  HEADER_LEN      = 8'd4;
  localparam logic [15:0] MAX_STRUCT_RST  = 16'hFFFF;

  localparam walk_state_t WALK_RESET = '{
    byte_pos:    16'd0,
    start_pos:   16'd0,
    phase:       PH_HEADER,
    fmt_len:     8'd0,
    held_type:   8'd0,
    held_handle: 16'd0,
    prev_zero:   1'b0,
    seen:        16'd0,
    stopped:     1'b0
  };

endpackage

// ===== src/ssw_step.sv =====
// next-state and record logic for one table byte
module ssw_step (
  input  ssw_pkg::walk_state_t  cur,
  input  logic [7:0]            table_byte,
  input  logic                  last_byte,
  input  logic [15:0]           max_structures,
  output ssw_pkg::walk_state_t  nxt,
  output ssw_pkg::walk_result_t res,
  output logic                  emit
);

  logic [15:0] pos;
  logic        done;

  assign pos = cur.byte_pos - cur.start_pos;

  always_comb begin
    nxt  = cur;
    res  = '0;
    emit = 1'b0;
    done = 1'b0;
    if (!cur.stopped) begin
      // count check at the first byte of each structure
      if (cur.phase == ssw_pkg::PH_HEADER && pos == 16'd0 &&
          cur.seen >= max_structures) begin
        nxt.stopped = 1'b1;
      end else begin
        unique case (cur.phase)
          ssw_pkg::PH_FORMATTED: begin
            if (({1'b0, pos} + 17'd1) >= {9'd0, cur.fmt_len}) begin
              nxt.phase     = ssw_pkg::PH_STRINGS;
              nxt.prev_zero = 1'b0;
            end
          end
          ssw_pkg::PH_STRINGS: begin
            // string set ends on two zero bytes in a row
            if (table_byte == 8'd0 && cur.prev_zero) begin
              done = 1'b1;
            end else begin
              nxt.prev_zero = (table_byte == 8'd0);
            end
          end
          default: begin
            // header bytes: type, length, handle low, handle high
            if (pos == 16'd0) begin
              nxt.held_type   = table_byte;
              nxt.held_handle = 16'd0;
              nxt.fmt_len     = ssw_pkg::HEADER_LEN;
            end else if (pos == 16'd1) begin
              nxt.fmt_len = (table_byte < ssw_pkg::HEADER_LEN) ? ssw_pkg::HEADER_LEN
                                                                : table_byte;
            end else if (pos == 16'd2) begin
              nxt.held_handle = {cur.held_handle[15:8], table_byte};
            end else begin
              nxt.held_handle = {table_byte, cur.held_handle[7:0]};
              nxt.phase       = (cur.fmt_len > ssw_pkg::HEADER_LEN) ?
                                ssw_pkg::PH_FORMATTED : ssw_pkg::PH_STRINGS;
              nxt.prev_zero   = 1'b0;
            end
          end
        endcase
        // structure complete or cut off by the table end
        if (done || last_byte) begin
          emit          = 1'b1;
          res.index     = cur.seen;
          res.stype     = nxt.held_type;
          res.handle    = nxt.held_handle;
          res.length    = pos + 16'd1;
          res.offset    = cur.start_pos;
          res.truncated = !done;
          nxt.seen        = cur.seen + 16'd1;
          nxt.phase       = ssw_pkg::PH_HEADER;
          nxt.start_pos   = cur.byte_pos + 16'd1;
          nxt.held_type   = 8'd0;
          nxt.held_handle = 16'd0;
          nxt.fmt_len     = 8'd0;
          nxt.prev_zero   = 1'b0;
        end
      end
    end
    nxt.byte_pos = cur.byte_pos + 16'd1;
    // table end restarts the walk
    if (last_byte) begin
      nxt = ssw_pkg::WALK_RESET;
    end
  end

endmodule

// ===== src/smbios_structure_walker.sv =====
// smbios structure walker top level: byte intake, record register, count register
// record: a structure record is registered and appears in the cycle after the byte that completes it
// throughput: one table byte per cycle; the state update for each byte is a single
// combinational step into the walker registers, stalling only while the record
// register is full and not taken
// reset: synchronous active-low rst_n clears the walk state; max count resets to 65535
module smbios_structure_walker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_structures,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_table_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_struct_index,
  output logic [7:0]  out_struct_type,
  output logic [15:0] out_struct_handle,
  output logic [15:0] out_struct_length,
  output logic [15:0] out_struct_offset,
  output logic        out_truncated
);

  ssw_pkg::walk_state_t  state_r;
  ssw_pkg::walk_state_t  state_nxt;
  ssw_pkg::walk_result_t res_r;
  ssw_pkg::walk_result_t step_res;
  logic                  step_emit;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [15:0]           max_r;
  logic                  in_accept;

  // count register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= ssw_pkg::MAX_STRUCT_RST;
    end else if (cfg_valid) begin
      max_r <= cfg_max_structures;
    end
  end

  // take a byte whenever the record register can make room
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  ssw_step u_step (
    .cur            (state_r),
    .table_byte     (in_table_byte),
    .last_byte      (in_last_byte),
    .max_structures (max_r),
    .nxt            (state_nxt),
    .res            (step_res),
    .emit           (step_emit)
  );

  // walker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssw_pkg::WALK_RESET;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // record register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept && step_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && step_emit) begin
      res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_struct_index  = res_r.index;
  assign out_struct_type   = res_r.stype;
  assign out_struct_handle = res_r.handle;
  assign out_struct_length = res_r.length;
  assign out_struct_offset = res_r.offset;
  assign out_truncated     = res_r.truncated;

  // table end always restarts at offset zero
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_last_byte) |=> (state_r.byte_pos == 16'd0 && !state_r.stopped))
    else $error("walk did not restart after table end");

  // a stopped walk yields no records
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.stopped |-> !step_emit)
    else $error("record produced after walk stopped");

  // record index follows the structure count
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && step_emit) |=> (out_valid && out_struct_index == $past(state_r.seen)))
    else $error("record index does not match structure count");

endmodule
